// ===== hw/rtl/pcd_pkg.sv =====
// Shared constants, payload structs and control types of the path conflict detector.
package pcd_pkg;

   localparam int MAX_AGENTS = 16;
   localparam int MAX_STEPS  = 256;
   localparam int COORD_BITS = 10;
   localparam int TIME_BITS  = 12;

   localparam int AGENT_BITS = $clog2(MAX_AGENTS);
   localparam int STEP_BITS  = $clog2(MAX_STEPS);
   localparam int LEN_BITS   = STEP_BITS + 1;
   localparam int CNT_BITS   = AGENT_BITS + 1;
   localparam int ADDR_BITS  = AGENT_BITS + STEP_BITS;
   localparam int MEM_DEPTH  = MAX_AGENTS * MAX_STEPS;

   localparam int AGENT_COUNT_BITS = 5;
   localparam logic [AGENT_COUNT_BITS-1:0] AGENT_COUNT_RESET = 5'd2;

   localparam int CSR_ADDR_BITS = 3;
   localparam int CSR_DATA_BITS = 32;
   localparam int CSR_IDX_BITS  = CSR_ADDR_BITS - 2;
   localparam logic [CSR_IDX_BITS-1:0] CSR_AGENT_COUNT = '0;

   localparam logic [1:0] REQ_LOAD_WP = 2'd0;
   localparam logic [1:0] REQ_SET_LEN = 2'd1;
   localparam logic [1:0] REQ_CHECK   = 2'd2;

   localparam logic KIND_VERTEX = 1'b0;
   localparam logic KIND_EDGE   = 1'b1;

   typedef struct packed {
      logic [1:0]  req_type;
      logic [3:0]  agent_id;
      logic [7:0]  step_index;
      logic [9:0]  pos_x;
      logic [9:0]  pos_y;
      logic [11:0] stamp;
      logic [8:0]  path_len;
   } req_data_type;

   typedef struct packed {
      logic        found;
      logic        conflict_kind;
      logic [3:0]  agent_first;
      logic [3:0]  agent_second;
      logic [11:0] time_first;
      logic [11:0] time_second;
      logic [9:0]  x_first;
      logic [9:0]  y_first;
      logic [9:0]  x_second;
      logic [9:0]  y_second;
   } rsp_data_type;

   typedef struct packed {
      logic [COORD_BITS-1:0] x;
      logic [COORD_BITS-1:0] y;
      logic [TIME_BITS-1:0]  t;
   } waypoint_type;

   typedef enum logic [5:0] {
      ST_IDLE  = 6'b000001,
      ST_PAIR  = 6'b000010,
      ST_LEN   = 6'b000100,
      ST_PRIME = 6'b001000,
      ST_SCAN  = 6'b010000,
      ST_DONE  = 6'b100000
   } state_type;

   typedef struct packed {
      logic write_wp;
      logic write_len;
      logic start;
      logic len_first;
      logic len_second;
      logic prime;
      logic step;
      logic advance;
      logic hit;
      logic load_result;
   } cmd_type;

   typedef struct packed {
      logic pairs_done;
      logic same_pair;
      logic len_zero;
      logic vertex_hit;
      logic edge_hit;
      logic step_last;
   } status_type;

endpackage

// ===== hw/rtl/pcd_ctrl.sv =====
// Controller state machine of the path conflict detector.
module pcd_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_ready,
   input  logic [1:0]           req_type,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output pcd_pkg::cmd_type     cmd,
   input  pcd_pkg::status_type  status
);

   pcd_pkg::state_type state_ff, state_in;
   logic               rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      unique case (state_ff)
         pcd_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               unique case (req_type)
                  pcd_pkg::REQ_LOAD_WP: cmd.write_wp = 1'b1;
                  pcd_pkg::REQ_SET_LEN: cmd.write_len = 1'b1;
                  pcd_pkg::REQ_CHECK: begin
                     cmd.start = 1'b1;
                     state_in  = pcd_pkg::ST_PAIR;
                  end
                  default: ;
               endcase
            end
         end
         pcd_pkg::ST_PAIR: begin
            priority if (status.pairs_done) begin
               state_in = pcd_pkg::ST_DONE;
            end else if (status.same_pair) begin
               cmd.advance = 1'b1;
            end else begin
               cmd.len_first = 1'b1;
               state_in      = pcd_pkg::ST_LEN;
            end
         end
         pcd_pkg::ST_LEN: begin
            cmd.len_second = 1'b1;
            if (status.len_zero) begin
               cmd.advance = 1'b1;
               state_in    = pcd_pkg::ST_PAIR;
            end else begin
               state_in = pcd_pkg::ST_PRIME;
            end
         end
         pcd_pkg::ST_PRIME: begin
            cmd.prime = 1'b1;
            state_in  = pcd_pkg::ST_SCAN;
         end
         pcd_pkg::ST_SCAN: begin
            // The vertex test wins over the swap test at the same step.
            priority if (status.vertex_hit || status.edge_hit) begin
               cmd.hit  = 1'b1;
               state_in = pcd_pkg::ST_DONE;
            end else if (status.step_last) begin
               cmd.advance = 1'b1;
               state_in    = pcd_pkg::ST_PAIR;
            end else begin
               cmd.step = 1'b1;
            end
         end
         pcd_pkg::ST_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_result = 1'b1;
               state_in        = pcd_pkg::ST_IDLE;
            end
         end
         default: state_in = pcd_pkg::ST_IDLE;
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      priority if (cmd.load_result) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= pcd_pkg::ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign rsp_valid = rsp_valid_ff;

endmodule

// ===== hw/rtl/pcd_datapath.sv =====
// Datapath of the path conflict detector: path memory, lengths, pair and step counters.
module pcd_datapath (
   input  logic                                   clock,
   input  logic                                   reset,
   input  pcd_pkg::req_data_type                  req_data,
   input  logic [pcd_pkg::AGENT_COUNT_BITS-1:0]   agent_count,
   input  pcd_pkg::cmd_type                       cmd,
   output pcd_pkg::status_type                    status,
   output pcd_pkg::rsp_data_type                  rsp_data
);

   // Waypoint memory, one row of MAX_STEPS entries per agent.
   pcd_pkg::waypoint_type path_mem_ff [pcd_pkg::MEM_DEPTH];
   pcd_pkg::waypoint_type rd1_ff, rd2_ff;
   pcd_pkg::waypoint_type cur1_ff, cur1_in;
   pcd_pkg::waypoint_type cur2_ff, cur2_in;

   logic [pcd_pkg::LEN_BITS-1:0] len_regs_ff [pcd_pkg::MAX_AGENTS];
   logic [pcd_pkg::LEN_BITS-1:0] len1_ff, len1_in;
   logic [pcd_pkg::LEN_BITS-1:0] len_ff, len_in;
   logic [pcd_pkg::LEN_BITS-1:0] t_ff, t_in;
   logic [pcd_pkg::CNT_BITS-1:0] a1_ff, a1_in;
   logic [pcd_pkg::CNT_BITS-1:0] a2_ff, a2_in;
   logic [pcd_pkg::CNT_BITS-1:0] n_ff, n_in;
   logic                         found_ff, found_in;
   logic                         kind_ff, kind_in;
   pcd_pkg::rsp_data_type        rsp_ff, rsp_in;

   logic [pcd_pkg::AGENT_BITS-1:0] wr_agent;
   logic [pcd_pkg::STEP_BITS-1:0]  wr_step;
   logic                           wr_agent_ok;
   logic                           wr_step_ok;
   logic [pcd_pkg::LEN_BITS-1:0]   wr_len;
   logic [pcd_pkg::AGENT_BITS-1:0] len_addr;
   logic [pcd_pkg::LEN_BITS-1:0]   len_rd;
   logic [pcd_pkg::LEN_BITS-1:0]   len_min;
   logic [pcd_pkg::STEP_BITS-1:0]  rd_step;
   logic                           rd_en;
   logic [pcd_pkg::CNT_BITS-1:0]   a2_next;
   logic                           swap_hit;

   assign wr_agent    = pcd_pkg::AGENT_BITS'(req_data.agent_id);
   assign wr_step     = pcd_pkg::STEP_BITS'(req_data.step_index);
   assign wr_agent_ok = int'(req_data.agent_id) < pcd_pkg::MAX_AGENTS;
   assign wr_step_ok  = int'(req_data.step_index) < pcd_pkg::MAX_STEPS;
   assign wr_len      = (int'(req_data.path_len) > pcd_pkg::MAX_STEPS) ?
                        pcd_pkg::LEN_BITS'(pcd_pkg::MAX_STEPS) :
                        pcd_pkg::LEN_BITS'(req_data.path_len);

   // One length read a cycle: first agent in the pair state, second in the length state.
   assign len_addr = cmd.len_second ? a2_ff[pcd_pkg::AGENT_BITS-1:0] :
                                      a1_ff[pcd_pkg::AGENT_BITS-1:0];
   assign len_rd   = len_regs_ff[len_addr];
   assign len_min  = (len1_ff <= len_rd) ? len1_ff : len_rd;

   // The read data always runs one step ahead of the current waypoints.
   always_comb begin
      priority if (cmd.step) begin
         rd_step = t_ff[pcd_pkg::STEP_BITS-1:0] + pcd_pkg::STEP_BITS'(2);
      end else if (cmd.prime) begin
         rd_step = t_ff[pcd_pkg::STEP_BITS-1:0] + pcd_pkg::STEP_BITS'(1);
      end else begin
         rd_step = '0;
      end
   end
   assign rd_en = cmd.len_second | cmd.prime | cmd.step;

   always_ff @(posedge clock) begin
      if (cmd.write_wp && wr_agent_ok && wr_step_ok) begin
         path_mem_ff[{wr_agent, wr_step}] <= '{x: pcd_pkg::COORD_BITS'(req_data.pos_x),
                                              y: pcd_pkg::COORD_BITS'(req_data.pos_y),
                                              t: pcd_pkg::TIME_BITS'(req_data.stamp)};
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd1_ff <= path_mem_ff[{a1_ff[pcd_pkg::AGENT_BITS-1:0], rd_step}];
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd2_ff <= path_mem_ff[{a2_ff[pcd_pkg::AGENT_BITS-1:0], rd_step}];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < pcd_pkg::MAX_AGENTS; i++) begin
            len_regs_ff[i] <= '0;
         end
      end else if (cmd.write_len && wr_agent_ok) begin
         len_regs_ff[wr_agent] <= wr_len;
      end
   end

   assign a2_next  = a2_ff + pcd_pkg::CNT_BITS'(1);
   assign swap_hit = (cur1_ff.x == rd2_ff.x) && (cur1_ff.y == rd2_ff.y) &&
                     (cur2_ff.x == rd1_ff.x) && (cur2_ff.y == rd1_ff.y);

   always_comb begin
      status.pairs_done = (a1_ff == n_ff);
      status.same_pair  = (a1_ff == a2_ff);
      status.len_zero   = (len_min == '0);
      status.step_last  = (pcd_pkg::LEN_BITS'(t_ff + pcd_pkg::LEN_BITS'(1)) >= len_ff);
      status.vertex_hit = (cur1_ff.x == cur2_ff.x) && (cur1_ff.y == cur2_ff.y) &&
                          (cur1_ff.t == cur2_ff.t);
      status.edge_hit   = swap_hit && !status.step_last;
   end

   always_comb begin
      a1_in    = a1_ff;
      a2_in    = a2_ff;
      n_in     = n_ff;
      found_in = found_ff;
      kind_in  = kind_ff;
      len1_in  = len1_ff;
      len_in   = len_ff;
      t_in     = t_ff;
      cur1_in  = cur1_ff;
      cur2_in  = cur2_ff;
      if (cmd.start) begin
         a1_in    = '0;
         a2_in    = '0;
         n_in     = (int'(agent_count) > pcd_pkg::MAX_AGENTS) ?
                    pcd_pkg::CNT_BITS'(pcd_pkg::MAX_AGENTS) :
                    pcd_pkg::CNT_BITS'(agent_count);
         found_in = 1'b0;
         kind_in  = pcd_pkg::KIND_VERTEX;
      end
      if (cmd.advance) begin
         if (a2_next == n_ff) begin
            a2_in = '0;
            a1_in = a1_ff + pcd_pkg::CNT_BITS'(1);
         end else begin
            a2_in = a2_next;
         end
      end
      if (cmd.len_first) begin
         len1_in = len_rd;
      end
      if (cmd.len_second) begin
         len_in = len_min;
         t_in   = '0;
      end
      if (cmd.prime) begin
         cur1_in = rd1_ff;
         cur2_in = rd2_ff;
      end
      if (cmd.step) begin
         cur1_in = rd1_ff;
         cur2_in = rd2_ff;
         t_in    = t_ff + pcd_pkg::LEN_BITS'(1);
      end
      if (cmd.hit) begin
         found_in = 1'b1;
         kind_in  = status.vertex_hit ? pcd_pkg::KIND_VERTEX : pcd_pkg::KIND_EDGE;
      end
   end

   always_comb begin
      rsp_in = rsp_ff;
      if (cmd.load_result) begin
         rsp_in = '0;
         if (found_ff) begin
            rsp_in.found         = 1'b1;
            rsp_in.conflict_kind = kind_ff;
            rsp_in.agent_first   = 4'(a1_ff);
            rsp_in.agent_second  = 4'(a2_ff);
            rsp_in.time_first    = 12'(cur1_ff.t);
            rsp_in.x_first       = 10'(cur1_ff.x);
            rsp_in.y_first       = 10'(cur1_ff.y);
            if (kind_ff == pcd_pkg::KIND_EDGE) begin
               rsp_in.time_second = 12'(rd1_ff.t);
               rsp_in.x_second    = 10'(rd1_ff.x);
               rsp_in.y_second    = 10'(rd1_ff.y);
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_ff    <= '0;
         a2_ff    <= '0;
         n_ff     <= '0;
         found_ff <= 1'b0;
         kind_ff  <= pcd_pkg::KIND_VERTEX;
         t_ff     <= '0;
      end else begin
         a1_ff    <= a1_in;
         a2_ff    <= a2_in;
         n_ff     <= n_in;
         found_ff <= found_in;
         kind_ff  <= kind_in;
         t_ff     <= t_in;
      end
   end

   always_ff @(posedge clock) begin
      len1_ff <= len1_in;
      len_ff  <= len_in;
      cur1_ff <= cur1_in;
      cur2_ff <= cur2_in;
      rsp_ff  <= rsp_in;
   end

   assign rsp_data = rsp_ff;

endmodule

// ===== hw/rtl/path_conflict_detector_top.sv =====
// Top level of the path conflict detector: register port, controller and datapath.
//
//   channel   direction  handshake                       word
//   req       in         req_valid / req_ready           pcd_pkg::req_data_type
//   rsp       out        rsp_valid / rsp_ready           pcd_pkg::rsp_data_type
//   csr       in/out     psel, penable, pwrite, pready   agent_count at address 0
//
// Waypoint and length loads are taken in the idle state; loads can arrive back to back.
// A check walks the ordered agent pairs; it skips pairs of equal agents and pairs whose
// shorter path length L is zero, and scans the others over L steps until the first hit;
// the two read ports of the waypoint memory set one step a cycle.
// Synchronous reset clears the lengths and sets agent_count to 2; waypoints are not cleared.
// A finished result waits in the output register while loads keep being accepted;
// a check waits at its end only if the previous result has not been taken yet.
module path_conflict_detector_top (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                req_valid,
   output logic                                req_ready,
   input  pcd_pkg::req_data_type               req_data,
   output logic                                rsp_valid,
   input  logic                                rsp_ready,
   output pcd_pkg::rsp_data_type               rsp_data,
   input  logic                                psel,
   input  logic                                penable,
   input  logic                                pwrite,
   input  logic [pcd_pkg::CSR_ADDR_BITS-1:0]   paddr,
   input  logic [pcd_pkg::CSR_DATA_BITS-1:0]   pwdata,
   output logic [pcd_pkg::CSR_DATA_BITS-1:0]   prdata,
   output logic                                pready
);

   logic [pcd_pkg::AGENT_COUNT_BITS-1:0] agent_count_ff, agent_count_in;
   logic [pcd_pkg::CSR_IDX_BITS-1:0]     csr_idx;
   logic                                 csr_write;
   pcd_pkg::cmd_type                     cmd;
   pcd_pkg::status_type                  status;

   assign pready    = 1'b1;
   assign csr_idx   = paddr[pcd_pkg::CSR_ADDR_BITS-1:2];
   assign csr_write = psel && penable && pwrite && pready;

   always_comb begin
      agent_count_in = agent_count_ff;
      if (csr_write && (csr_idx == pcd_pkg::CSR_AGENT_COUNT)) begin
         agent_count_in = pwdata[pcd_pkg::AGENT_COUNT_BITS-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         agent_count_ff <= pcd_pkg::AGENT_COUNT_RESET;
      end else begin
         agent_count_ff <= agent_count_in;
      end
   end

   assign prdata = (csr_idx == pcd_pkg::CSR_AGENT_COUNT) ?
                   pcd_pkg::CSR_DATA_BITS'(agent_count_ff) : '0;

   pcd_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_type  (req_data.req_type),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (cmd),
      .status    (status)
   );

   pcd_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_data    (req_data),
      .agent_count (agent_count_ff),
      .cmd         (cmd),
      .status      (status),
      .rsp_data    (rsp_data)
   );

endmodule

// ===== hw/rtl/pcd_checker.sv =====
// Port checker of the path conflict detector and its bind to the top level.
module pcd_checker (
   input logic                  clock,
   input logic                  reset,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input pcd_pkg::rsp_data_type rsp_data
);

   // A result that is not taken stays on the port unchanged.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_data))
      else $error("result word changed or dropped while stalled");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_data.found |-> rsp_data == '0)
      else $error("no-conflict result carries nonzero fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found && (rsp_data.conflict_kind == pcd_pkg::KIND_VERTEX)
      |-> rsp_data.time_second == '0 && rsp_data.x_second == '0 &&
          rsp_data.y_second == '0)
      else $error("vertex conflict carries next-step fields");

   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_data.found |-> rsp_data.agent_first != rsp_data.agent_second)
      else $error("conflict reported between an agent and itself");

endmodule

bind path_conflict_detector_top pcd_checker u_pcd_checker (
   .clock     (clock),
   .reset     (reset),
   .rsp_valid (rsp_valid),
   .rsp_ready (rsp_ready),
   .rsp_data  (rsp_data)
);

// ===== sim/tb_path_conflict_detector_top.sv =====
// Self-checking testbench for the path conflict detector, with a built-in predictor of the scan.
module tb_path_conflict_detector_top;

   localparam logic [1:0] REQ_UNUSED = 2'd3;
   localparam logic [pcd_pkg::CSR_ADDR_BITS-1:0] AGENT_COUNT_ADDR =
      {pcd_pkg::CSR_AGENT_COUNT, 2'b00};
   localparam int CYCLE_LIMIT   = 2_000_000;
   localparam int SETTLE_CYCLES = 16;
   localparam int DRAIN_CYCLES  = 64;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_ready;
   pcd_pkg::req_data_type req_data = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   pcd_pkg::rsp_data_type rsp_data;
   logic psel = 1'b0;
   logic penable = 1'b0;
   logic pwrite = 1'b0;
   logic [pcd_pkg::CSR_ADDR_BITS-1:0] paddr = '0;
   logic [pcd_pkg::CSR_DATA_BITS-1:0] pwdata = '0;
   logic [pcd_pkg::CSR_DATA_BITS-1:0] prdata;
   logic pready;

   // Predictor state: the path memory, its written map, the lengths and the agent count.
   pcd_pkg::waypoint_type route_mem [pcd_pkg::MAX_AGENTS][pcd_pkg::MAX_STEPS];
   bit route_written [pcd_pkg::MAX_AGENTS][pcd_pkg::MAX_STEPS];
   logic [8:0] route_len [pcd_pkg::MAX_AGENTS] = '{default: '0};
   logic [4:0] model_agent_count = pcd_pkg::AGENT_COUNT_RESET;

   pcd_pkg::rsp_data_type expected_conflicts[$];
   pcd_pkg::rsp_data_type want_word;
   pcd_pkg::rsp_data_type got_word;
   int mismatch_count = 0;
   int items_sent = 0;
   int burst_left = 0;
   int stall_left = 0;
   int cycle_count = 0;

   path_conflict_detector_top dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_data  (rsp_data),
      .psel      (psel),
      .penable   (penable),
      .pwrite    (pwrite),
      .paddr     (paddr),
      .pwdata    (pwdata),
      .prdata    (prdata),
      .pready    (pready)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("*** FAILED ***");
         $finish;
      end
   end

   // The receiver never stalls for one third of the run, in regular windows, and stalls in
   // random stretches for the rest.
   always @(posedge clock) begin
      if ((cycle_count / 400) % 3 == 0) begin
         rsp_ready <= 1'b1;
      end else if (stall_left > 0) begin
         rsp_ready <= 1'b0;
         stall_left <= stall_left - 1;
      end else begin
         rsp_ready <= 1'b1;
         if ($urandom_range(0, 5) == 0) stall_left <= $urandom_range(1, 12);
      end
   end

   task automatic report_mismatch(input string msg);
      $display("ERROR cycle %0d: %s", cycle_count, msg);
      mismatch_count++;
   endtask

   task automatic report_field(input string name, input int got, input int want);
      report_mismatch($sformatf("%s is %0d, expected %0d", name, got, want));
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && rsp_ready) begin
         got_word = rsp_data;
         if (expected_conflicts.size() == 0) begin
            report_mismatch("result word arrived with no check waiting");
         end else begin
            want_word = expected_conflicts.pop_front();
            if (got_word.found !== want_word.found)
               report_field("found", int'(got_word.found), int'(want_word.found));
            if (got_word.conflict_kind !== want_word.conflict_kind)
               report_field("conflict_kind", int'(got_word.conflict_kind),
                            int'(want_word.conflict_kind));
            if (got_word.agent_first !== want_word.agent_first)
               report_field("agent_first", int'(got_word.agent_first),
                            int'(want_word.agent_first));
            if (got_word.agent_second !== want_word.agent_second)
               report_field("agent_second", int'(got_word.agent_second),
                            int'(want_word.agent_second));
            if (got_word.time_first !== want_word.time_first)
               report_field("time_first", int'(got_word.time_first),
                            int'(want_word.time_first));
            if (got_word.time_second !== want_word.time_second)
               report_field("time_second", int'(got_word.time_second),
                            int'(want_word.time_second));
            if (got_word.x_first !== want_word.x_first)
               report_field("x_first", int'(got_word.x_first), int'(want_word.x_first));
            if (got_word.y_first !== want_word.y_first)
               report_field("y_first", int'(got_word.y_first), int'(want_word.y_first));
            if (got_word.x_second !== want_word.x_second)
               report_field("x_second", int'(got_word.x_second), int'(want_word.x_second));
            if (got_word.y_second !== want_word.y_second)
               report_field("y_second", int'(got_word.y_second), int'(want_word.y_second));
         end
      end
   end

   // Walks ordered agent pairs over the shorter path; the vertex test comes before
   // the swap test at each step, and the first hit ends the scan.
   function automatic pcd_pkg::rsp_data_type scan_for_conflict();
      pcd_pkg::rsp_data_type hit;
      int n;
      int span;
      pcd_pkg::waypoint_type c1, c2, n1, n2;
      hit = '0;
      n = (int'(model_agent_count) > pcd_pkg::MAX_AGENTS) ? pcd_pkg::MAX_AGENTS :
                                                            int'(model_agent_count);
      for (int a1 = 0; a1 < n; a1++) begin
         for (int a2 = 0; a2 < n; a2++) begin
            if (a1 == a2) continue;
            span = (route_len[a1] <= route_len[a2]) ? int'(route_len[a1]) :
                                                      int'(route_len[a2]);
            for (int t = 0; t < span; t++) begin
               c1 = route_mem[a1][t];
               c2 = route_mem[a2][t];
               if (c1 == c2) begin
                  hit.found = 1'b1;
                  hit.conflict_kind = pcd_pkg::KIND_VERTEX;
                  hit.agent_first = 4'(a1);
                  hit.agent_second = 4'(a2);
                  hit.time_first = c1.t;
                  hit.x_first = c1.x;
                  hit.y_first = c1.y;
                  return hit;
               end
               if (t + 1 < span) begin
                  n1 = route_mem[a1][t + 1];
                  n2 = route_mem[a2][t + 1];
                  // Swaps compare cells only; the times may differ.
                  if (c1.x == n2.x && c1.y == n2.y && c2.x == n1.x && c2.y == n1.y) begin
                     hit.found = 1'b1;
                     hit.conflict_kind = pcd_pkg::KIND_EDGE;
                     hit.agent_first = 4'(a1);
                     hit.agent_second = 4'(a2);
                     hit.time_first = c1.t;
                     hit.time_second = n1.t;
                     hit.x_first = c1.x;
                     hit.y_first = c1.y;
                     hit.x_second = n1.x;
                     hit.y_second = n1.y;
                     return hit;
                  end
               end
            end
         end
      end
      return hit;
   endfunction

   function automatic void apply_word(input pcd_pkg::req_data_type w);
      unique case (w.req_type)
         pcd_pkg::REQ_LOAD_WP: begin
            route_mem[w.agent_id][w.step_index] = '{x: w.pos_x, y: w.pos_y, t: w.stamp};
            route_written[w.agent_id][w.step_index] = 1'b1;
         end
         pcd_pkg::REQ_SET_LEN: begin
            route_len[w.agent_id] = (int'(w.path_len) > pcd_pkg::MAX_STEPS) ?
                                    9'(pcd_pkg::MAX_STEPS) : w.path_len;
         end
         pcd_pkg::REQ_CHECK: begin
            expected_conflicts.insert(expected_conflicts.size(), scan_for_conflict());
         end
         default: ;
      endcase
   endfunction

   // Number of steps from zero that are written for an agent; lengths never exceed
   // it, so a check never reads an unwritten waypoint.
   function automatic int written_prefix(input logic [3:0] agent);
      int s;
      s = 0;
      while (s < pcd_pkg::MAX_STEPS && route_written[agent][s]) s++;
      return s;
   endfunction

   function automatic pcd_pkg::req_data_type random_word();
      bit [63:0] bits;
      bits = {$urandom, $urandom};
      return bits[$bits(pcd_pkg::req_data_type)-1:0];
   endfunction

   function automatic int pick_coord(input bit dense);
      return dense ? int'($urandom_range(0, 2)) : int'($urandom_range(0, 1023));
   endfunction

   function automatic int pick_stamp(input bit dense, input int step);
      return dense ? step + int'($urandom_range(0, 1)) : int'($urandom_range(0, 4095));
   endfunction

   task automatic send_word(input pcd_pkg::req_data_type word);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = $urandom_range(1, 24);
      end
      req_valid <= 1'b1;
      req_data <= word;
      do @(posedge clock); while (!req_ready);
      apply_word(word);
      burst_left--;
      items_sent++;
   endtask

   task automatic load_waypoint(input int agent, input int step,
                                input int x, input int y, input int t);
      pcd_pkg::req_data_type w;
      w = random_word();
      w.req_type = pcd_pkg::REQ_LOAD_WP;
      w.agent_id = 4'(agent);
      w.step_index = 8'(step);
      w.pos_x = 10'(x);
      w.pos_y = 10'(y);
      w.stamp = 12'(t);
      send_word(w);
   endtask

   task automatic set_length(input int agent, input int len);
      pcd_pkg::req_data_type w;
      w = random_word();
      w.req_type = pcd_pkg::REQ_SET_LEN;
      w.agent_id = 4'(agent);
      w.path_len = 9'(len);
      send_word(w);
   endtask

   task automatic request_check();
      pcd_pkg::req_data_type w;
      w = random_word();
      w.req_type = pcd_pkg::REQ_CHECK;
      send_word(w);
   endtask

   task automatic send_noise();
      pcd_pkg::req_data_type w;
      int limit;
      w = random_word();
      case ($urandom_range(0, 2))
         0: w.req_type = REQ_UNUSED;
         1: w.req_type = pcd_pkg::REQ_LOAD_WP;
         default: begin
            w.req_type = pcd_pkg::REQ_SET_LEN;
            limit = written_prefix(w.agent_id);
            w.path_len = (limit == pcd_pkg::MAX_STEPS) ? 9'($urandom_range(0, 511))
                                                       : 9'($urandom_range(0, limit));
         end
      endcase
      send_word(w);
   endtask

   // Copies a cell of one agent into another so that a vertex or a swap shows up.
   task automatic plant_conflict(input int n);
      int a1, a2, span, t;
      a1 = $urandom_range(0, n - 1);
      a2 = (a1 + $urandom_range(1, n - 1)) % n;
      span = (route_len[a1] <= route_len[a2]) ? int'(route_len[a1]) : int'(route_len[a2]);
      if (span == 0) return;
      t = $urandom_range(0, span - 1);
      if (t + 1 < span && $urandom_range(0, 1) == 1) begin
         load_waypoint(a2, t, int'(route_mem[a1][t + 1].x), int'(route_mem[a1][t + 1].y),
                       int'($urandom_range(0, 4095)));
         load_waypoint(a2, t + 1, int'(route_mem[a1][t].x), int'(route_mem[a1][t].y),
                       int'($urandom_range(0, 4095)));
      end else begin
         load_waypoint(a2, t, int'(route_mem[a1][t].x), int'(route_mem[a1][t].y),
                       int'(route_mem[a1][t].t));
      end
   endtask

   task automatic wait_until_idle();
      req_valid <= 1'b0;
      while (expected_conflicts.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic csr_access(input bit is_write, input logic [31:0] wdata,
                             output logic [31:0] rdata);
      @(posedge clock);
      psel <= 1'b1;
      penable <= 1'b0;
      pwrite <= is_write;
      paddr <= AGENT_COUNT_ADDR;
      pwdata <= wdata;
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      rdata = prdata;
      psel <= 1'b0;
      penable <= 1'b0;
   endtask

   task automatic csr_read_expect(input logic [4:0] want);
      logic [31:0] rd;
      csr_access(1'b0, $urandom, rd);
      if (rd !== {27'b0, want})
         report_mismatch($sformatf("agent_count reads %0d, expected %0d", rd, want));
   endtask

   task automatic program_agent_count(input int value);
      logic [31:0] wdata;
      logic [31:0] rd;
      wait_until_idle();
      // Upper bits are junk; only the low five bits belong to the register.
      wdata = $urandom;
      wdata[4:0] = 5'(value);
      csr_access(1'b1, wdata, rd);
      model_agent_count = 5'(value);
      csr_read_expect(5'(value));
   endtask

   task automatic test_reset_register();
      csr_read_expect(pcd_pkg::AGENT_COUNT_RESET);
   endtask

   task automatic test_empty_paths();
      request_check();
      load_waypoint(15, 255, 0, 1023, 0);
   endtask

   task automatic test_vertex_conflict();
      load_waypoint(0, 0, 0, 0, 0);
      load_waypoint(0, 1, 1023, 1023, 4095);
      load_waypoint(1, 0, 5, 5, 0);
      load_waypoint(1, 1, 1023, 1023, 4095);
      set_length(0, 2);
      set_length(1, 2);
      request_check();
   endtask

   task automatic test_ignored_type();
      pcd_pkg::req_data_type w;
      // Looks like a waypoint write that would break the vertex hit, but must be dropped.
      w = random_word();
      w.req_type = REQ_UNUSED;
      w.agent_id = 4'd0;
      w.step_index = 8'd1;
      w.pos_x = 10'd7;
      w.path_len = 9'd0;
      send_word(w);
      request_check();
   endtask

   task automatic test_edge_swap();
      load_waypoint(0, 0, 3, 4, 10);
      load_waypoint(0, 1, 7, 8, 11);
      load_waypoint(1, 0, 7, 8, 20);
      load_waypoint(1, 1, 3, 4, 21);
      request_check();
   endtask

   task automatic test_short_path();
      set_length(1, 1);
      request_check();
      set_length(1, 2);
   endtask

   task automatic test_agent_count_extremes();
      program_agent_count(1);
      request_check();
      program_agent_count(0);
      request_check();
      program_agent_count(31);
      request_check();
      program_agent_count(2);
   endtask

   task automatic run_fleet();
      int n, cfg, pick, len;
      bit dense;
      pick = $urandom_range(0, 9);
      if (pick == 0) begin
         n = pcd_pkg::MAX_AGENTS;
         cfg = $urandom_range(16, 31);
      end else if (pick == 1) begin
         n = 3;
         cfg = $urandom_range(0, 1);
      end else begin
         n = $urandom_range(2, 6);
         cfg = n;
      end
      if (cfg != int'(model_agent_count)) program_agent_count(cfg);
      // Dense fleets share a tiny grid and collide often; sparse ones rarely do.
      dense = ($urandom_range(0, 3) != 0);
      for (int a = 0; a < n; a++) begin
         len = $urandom_range(0, (n == pcd_pkg::MAX_AGENTS) ? 5 : 12);
         for (int s = 0; s < len; s++) begin
            load_waypoint(a, s, pick_coord(dense), pick_coord(dense), pick_stamp(dense, s));
            if ($urandom_range(0, 7) == 0) send_noise();
         end
         set_length(a, len);
      end
      repeat ($urandom_range(1, 3)) begin
         repeat ($urandom_range(0, 2)) plant_conflict(n);
         request_check();
      end
   endtask

   task automatic test_random_fleets(input int target);
      while (items_sent < target) run_fleet();
   endtask

   task automatic test_long_path();
      int tie;
      if (model_agent_count != 5'd2) program_agent_count(2);
      for (int s = 0; s < pcd_pkg::MAX_STEPS; s++)
         load_waypoint(0, s, int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                       int'($urandom_range(0, 4095)));
      // An oversized length whose low byte falls short of the planted vertex.
      set_length(0, int'($urandom_range(pcd_pkg::MAX_STEPS + 1, pcd_pkg::MAX_STEPS + 49)));
      for (int s = 0; s < 100; s++)
         load_waypoint(1, s, int'($urandom_range(0, 1023)), int'($urandom_range(0, 1023)),
                       int'($urandom_range(0, 4095)));
      tie = $urandom_range(50, 99);
      load_waypoint(1, tie, int'(route_mem[0][tie].x), int'(route_mem[0][tie].y),
                    int'(route_mem[0][tie].t));
      set_length(1, 100);
      request_check();
      set_length(0, pcd_pkg::MAX_STEPS);
      request_check();
   endtask

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      test_reset_register();
      test_empty_paths();
      test_vertex_conflict();
      test_ignored_type();
      test_edge_swap();
      test_short_path();
      test_agent_count_extremes();
      test_random_fleets(480);
      test_long_path();
      test_random_fleets(900);
      wait_until_idle();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (mismatch_count == 0)
         $display("*** PASSED ***");
      else
         $display("*** FAILED ***");
      $finish;
   end

endmodule
